FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define PL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/plist_pkg.sv
// Shared types and constants for the positional list block
package plist_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         element_total;
        logic               is_empty;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } plist_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } plist_state_t;

endpackage

FILE: hdl/plist_ctrl.sv
// Controller state machine: request handshake, execute step, result handshake
module plist_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output plist_pkg::plist_cmd_t cmd
);
    import plist_pkg::*;

    plist_state_t state_reg;
    plist_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/plist_dpath.sv
// Datapath: row of shifting entry cells, entry count and result register
module plist_dpath #(
    parameter int CAPACITY = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  plist_pkg::req_t       req,
    input  plist_pkg::plist_cmd_t cmd,
    output plist_pkg::rsp_t       rsp
);
    import plist_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > 6) ? CW : 6;

    req_t                   req_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic signed [31:0]     cells_reg  [CAPACITY];
    logic signed [31:0]     cells_next [CAPACITY];

    logic [CMPW-1:0]        pos_c;
    logic [CMPW-1:0]        cnt_c;
    logic [CMPW-1:0]        tgt;
    logic                   in_range;
    logic                   full;
    logic                   do_ins;
    logic                   do_del;
    logic [IW-1:0]          rd_idx;
    logic signed [31:0]     rd_val;

    assign pos_c    = CMPW'(req_reg.position);
    assign cnt_c    = CMPW'(count_reg);
    assign in_range = pos_c < cnt_c;
    assign full     = count_reg == CW'(CAPACITY);
    assign tgt      = in_range ? pos_c : cnt_c;
    assign do_ins   = (req_reg.mode == MODE_INSERT) && !full;
    assign do_del   = (req_reg.mode == MODE_DELETE) && in_range;
    assign rd_idx   = pos_c[IW-1:0];

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        always_comb
        begin
            cells_next[g] = cells_reg[g];
            if (do_ins)
            begin
                if (CMPW'(g) == tgt)
                begin
                    cells_next[g] = req_reg.value;
                end
                else if (CMPW'(g) > tgt)
                begin
                    if (g > 0)
                    begin
                        cells_next[g] = cells_reg[(g > 0) ? g - 1 : 0];
                    end
                end
            end
            else if (do_del)
            begin
                if (CMPW'(g) >= pos_c)
                begin
                    if (g == CAPACITY - 1)
                    begin
                        cells_next[g] = '0;
                    end
                    else
                    begin
                        cells_next[g] = cells_reg[(g < CAPACITY - 1) ? g + 1 : g];
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cells_reg[g] <= '0;
            end
            else if (cmd.exec)
            begin
                cells_reg[g] <= cells_next[g];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        rd_val     = '0;
        rsp_next   = '0;
        case (req_reg.mode)
            MODE_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            MODE_DELETE:
            begin
                if (in_range)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    rsp_next.status = STAT_RANGE;
                end
            end
            MODE_READ:
            begin
                if (in_range)
                begin
                    rd_val = cells_reg[rd_idx];
                end
                else
                begin
                    rsp_next.status = STAT_RANGE;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.read_value    = rd_val;
        rsp_next.element_total = 7'(count_next);
        rsp_next.is_empty      = count_next == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: hdl/positional_list_insert_delete_top.sv
// Top level of the positional list: controller and datapath
// Flow: a request is registered on accept, run in ST_EXEC, and its result shown in ST_DONE.
// The controller holds one request at a time through capture, a parallel shift of the entry
// cells, and result handoff; a new request is accepted only after the result is taken.
// Reset: asynchronous active-low rst_n clears all entries to zero and the count to zero.
module positional_list_insert_delete_top #(
    parameter int CAPACITY = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  plist_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output plist_pkg::rsp_t rsp
);
    import plist_pkg::*;

    plist_cmd_t cmd;

    plist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    plist_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .rsp   (rsp)
    );

endmodule

FILE: hdl/plist_checker.sv
// Port-level assertion checker for the positional list, bound to the top level
`include "assert_macros.svh"

module plist_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input plist_pkg::rsp_t rsp
);
    import plist_pkg::*;

    `PL_ASSERT(a_rsp_hold, clk, rst_n,
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp),
        "result dropped or changed while stalled")
    `PL_ASSERT(a_no_early_rsp, clk, rst_n,
        req_valid && req_ready |=> !rsp_valid,
        "result shown in the cycle after request accept")
    `PL_ASSERT(a_one_in_flight, clk, rst_n,
        rsp_valid |-> !req_ready,
        "new request taken while a result waits")
    `PL_ASSERT(a_empty_flag, clk, rst_n,
        rsp_valid |-> (rsp.is_empty == (rsp.element_total == 7'd0)),
        "empty flag disagrees with count")
    `PL_ASSERT_ALWAYS(a_status_code, clk,
        rsp_valid |-> (rsp.status == STAT_OK || rsp.status == STAT_FULL || rsp.status == STAT_RANGE),
        "undefined status code")

endmodule

bind positional_list_insert_delete_top plist_checker u_plist_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
